// ===== rtl/multi_client_heartbeat_watchdog_macros.svh =====
// Assertion macros shared by the heartbeat watchdog RTL.
`ifndef MULTI_CLIENT_HEARTBEAT_WATCHDOG_MACROS_SVH
`define MULTI_CLIENT_HEARTBEAT_WATCHDOG_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HBW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HBW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hbw_pkg.sv =====
// Shared types and constants of the heartbeat watchdog.
package hbw_pkg;

  localparam int ID_W   = 22;
  localparam int TAG_W  = 32;
  localparam int PER_W  = 16;
  localparam int TIME_W = 32;
  localparam int MISS_W = 8;
  localparam int SLOT_W = 4;
  localparam int LIM_W  = MISS_W + PER_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_FEED     = 2'd1;
  localparam logic [1:0] ACT_UNREG    = 2'd2;
  localparam logic [1:0] ACT_TICK     = 2'd3;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  tag;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] last_feed;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } tbl_ctl_t;

endpackage

// ===== rtl/hbw_table.sv =====
// Client table: entry memory with registered read plus per-slot valid bits.
module hbw_table #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hbw_pkg::tbl_ctl_t ctl,
  input  logic [IW-1:0]    rd_addr,
  input  logic [IW-1:0]    wr_addr,
  input  hbw_pkg::entry_t  wr_data,
  output hbw_pkg::entry_t  rd_data,
  output logic             rd_valid
);
  import hbw_pkg::*;

  entry_t             mem [ENTRIES];
  entry_t             rd_data_r;
  logic               rd_valid_r;
  logic [ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (ctl.clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

// ===== rtl/hbw_ctrl.sv =====
// Command sequencer: slot scan, expiry check, table update and result register.
module hbw_ctrl #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [hbw_pkg::ID_W-1:0]    in_client_id,
  input  logic [hbw_pkg::TAG_W-1:0]   in_name_tag,
  input  logic [hbw_pkg::PER_W-1:0]   in_period,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [1:0]                  out_status,
  output logic [hbw_pkg::TAG_W-1:0]   out_client_tag,
  output logic [hbw_pkg::ID_W-1:0]    out_target_id,
  output logic [hbw_pkg::SLOT_W-1:0]  out_slot,
  output logic                        out_last,
  input  logic [hbw_pkg::MISS_W-1:0]  max_missed,
  input  logic [hbw_pkg::PER_W-1:0]   dflt_period,
  output hbw_pkg::tbl_ctl_t           tbl_ctl,
  output logic [IW-1:0]               tbl_rd_addr,
  output logic [IW-1:0]               tbl_wr_addr,
  output hbw_pkg::entry_t             tbl_wr_data,
  input  hbw_pkg::entry_t             tbl_rd_data,
  input  logic                        tbl_rd_valid
);
  import hbw_pkg::*;

  `include "multi_client_heartbeat_watchdog_macros.svh"

  localparam int SXW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        op_r;
  logic [ID_W-1:0]   id_r;
  logic [TAG_W-1:0]  tag_r;
  logic [PER_W-1:0]  per_r;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [IW-1:0]     eval_r, eval_nxt;
  logic              hit_found_r, hit_found_nxt;
  logic [IW-1:0]     hit_r, hit_nxt;
  entry_t            hit_word_r, hit_word_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IW-1:0]     free_r, free_nxt;

  logic              out_valid_r;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [TAG_W-1:0]  out_tag_r, out_tag_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;
  logic              out_free;

  logic              accept;
  logic              id_match, tag_match, slot_hit, expired, stall, last_slot;
  logic [TIME_W-1:0] elapsed;
  logic [LIM_W-1:0]  limit;
  logic [PER_W-1:0]  eff_period;
  logic [SXW-1:0]    eval_wide, hit_wide, free_wide;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign id_match  = tbl_rd_valid && (tbl_rd_data.id == id_r);
  assign tag_match = tbl_rd_valid && (tbl_rd_data.tag == tag_r);
  assign slot_hit  = (op_r == ACT_REGISTER) ? (id_match || tag_match) :
                     ((op_r != ACT_TICK) && id_match);
  assign elapsed   = now_r - tbl_rd_data.last_feed;
  assign limit     = LIM_W'(max_missed) * LIM_W'(tbl_rd_data.period);
  assign expired   = (op_r == ACT_TICK) && tbl_rd_valid && (elapsed > TIME_W'(limit));
  assign stall     = expired && !out_free;
  assign last_slot = (eval_r == LAST_SLOT);
  assign eff_period = (per_r == '0) ? dflt_period : per_r;

  assign eval_wide = SXW'(eval_r);
  assign hit_wide  = SXW'(hit_r);
  assign free_wide = SXW'(free_r);

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    eval_nxt       = eval_r;
    hit_found_nxt  = hit_found_r;
    hit_nxt        = hit_r;
    hit_word_nxt   = hit_word_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    out_load       = 1'b0;
    out_kind_nxt   = KIND_ACK;
    out_status_nxt = ST_OK;
    out_tag_nxt    = '0;
    out_id_nxt     = id_r;
    out_slot_nxt   = '0;
    out_last_nxt   = 1'b1;
    tbl_ctl        = '0;
    tbl_rd_addr    = '0;
    tbl_wr_addr    = eval_r;
    tbl_wr_data    = tbl_rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          tbl_ctl.rd_en  = 1'b1;
          eval_nxt       = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          if (in_action == ACT_TICK) begin
            now_nxt = now_r + 1'b1;
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (!hit_found_r && slot_hit) begin
            hit_found_nxt = 1'b1;
            hit_nxt       = eval_r;
            hit_word_nxt  = tbl_rd_data;
          end
          if (!free_found_r && !tbl_rd_valid) begin
            free_found_nxt = 1'b1;
            free_nxt       = eval_r;
          end
          if (expired) begin
            tbl_ctl.wr_en         = 1'b1;
            tbl_wr_data.last_feed = now_r;
            out_load              = 1'b1;
            out_kind_nxt          = KIND_RESTART;
            out_tag_nxt           = tbl_rd_data.tag;
            out_id_nxt            = tbl_rd_data.id;
            out_slot_nxt          = eval_wide[SLOT_W-1:0];
            out_last_nxt          = 1'b0;
          end
          if (last_slot) begin
            state_nxt = S_FINISH;
          end else begin
            tbl_ctl.rd_en = 1'b1;
            tbl_rd_addr   = eval_r + 1'b1;
            eval_nxt      = eval_r + 1'b1;
          end
        end
      end
      S_FINISH: begin
        tbl_wr_addr = hit_r;
        tbl_wr_data = hit_word_r;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          unique case (op_r)
            ACT_TICK: begin
              out_kind_nxt = KIND_DONE;
              out_id_nxt   = '0;
            end
            ACT_REGISTER: begin
              tbl_wr_data.id        = id_r;
              tbl_wr_data.period    = eff_period;
              tbl_wr_data.last_feed = now_r;
              if (hit_found_r) begin
                tbl_ctl.wr_en = 1'b1;
                out_slot_nxt  = hit_wide[SLOT_W-1:0];
              end else if (free_found_r) begin
                tbl_ctl.wr_en     = 1'b1;
                tbl_ctl.set_valid = 1'b1;
                tbl_wr_addr       = free_r;
                tbl_wr_data.tag   = tag_r;
                out_slot_nxt      = free_wide[SLOT_W-1:0];
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            ACT_FEED: begin
              if (hit_found_r) begin
                tbl_ctl.wr_en         = 1'b1;
                tbl_wr_data.last_feed = now_r;
                out_slot_nxt          = hit_wide[SLOT_W-1:0];
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              if (hit_found_r) begin
                tbl_ctl.clr_valid = 1'b1;
                out_slot_nxt      = hit_wide[SLOT_W-1:0];
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      now_r        <= '0;
      eval_r       <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      now_r        <= now_nxt;
      eval_r       <= eval_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    hit_word_r <= hit_word_nxt;
    free_r     <= free_nxt;
    if (accept) begin
      op_r  <= in_action;
      id_r  <= in_client_id;
      tag_r <= in_name_tag;
      per_r <= in_period;
    end
    if (out_load) begin
      out_kind_r   <= out_kind_nxt;
      out_status_r <= out_status_nxt;
      out_tag_r    <= out_tag_nxt;
      out_id_r     <= out_id_nxt;
      out_slot_r   <= out_slot_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_status     = out_status_r;
  assign out_client_tag = out_tag_r;
  assign out_target_id  = out_id_r;
  assign out_slot       = out_slot_r;
  assign out_last       = out_last_r;

  `HBW_ASSERT_NEXT(a_accept_starts_scan, accept, (state_r == S_SCAN) && (eval_r == '0), "accepted beat did not start a scan at slot zero")
  `HBW_ASSERT_NEXT(a_stall_holds_slot, (state_r == S_SCAN) && stall, $stable(eval_r), "scan slot advanced while a restart was blocked")
  `HBW_ASSERT_NOW(a_scan_write_tick_only, (state_r == S_SCAN) && tbl_ctl.wr_en, op_r == ACT_TICK, "table written during a non-tick scan")
  `HBW_ASSERT_NOW(a_single_valid_update, 1'b1, !(tbl_ctl.set_valid && tbl_ctl.clr_valid), "valid bit set and cleared together")
  `HBW_ASSERT_NOW(a_done_is_last, out_valid_r && (out_kind_r == KIND_DONE), out_last_r, "scan-done beat without last")

endmodule

// ===== rtl/multi_client_heartbeat_watchdog.sv =====
// Heartbeat watchdog top level: configuration registers, client table and sequencer.
// Each command reads all ENTRIES slots, one per cycle while no restart beat is held back by a
// full output register, then updates and loads a result. A new input beat is taken only in
// idle, once the final result beat of the previous command has been loaded.
// Reset clears valid bits, tick counter and output valid; 3 missed feeds, period 10.
module multi_client_heartbeat_watchdog #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic [hbw_pkg::ID_W-1:0]         in_client_id,
  input  logic [hbw_pkg::TAG_W-1:0]        in_name_tag,
  input  logic [hbw_pkg::PER_W-1:0]        in_period,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_kind,
  output logic [1:0]                       out_status,
  output logic [hbw_pkg::TAG_W-1:0]        out_client_tag,
  output logic [hbw_pkg::ID_W-1:0]         out_target_id,
  output logic [hbw_pkg::SLOT_W-1:0]       out_slot,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hbw_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [MISS_W-1:0] max_missed_r;
  logic [PER_W-1:0]  dflt_period_r;
  tbl_ctl_t          tbl_ctl;
  logic [IW-1:0]     tbl_rd_addr;
  logic [IW-1:0]     tbl_wr_addr;
  entry_t            tbl_wr_data;
  entry_t            tbl_rd_data;
  logic              tbl_rd_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_missed_r  <= MISS_W'(3);
      dflt_period_r <= PER_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_MISSED:     max_missed_r  <= cfg_data[MISS_W-1:0];
        CFG_DEFAULT_PERIOD: dflt_period_r <= cfg_data[PER_W-1:0];
        default: begin
          max_missed_r <= max_missed_r;
        end
      endcase
    end
  end

  hbw_table #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tbl_ctl),
    .rd_addr  (tbl_rd_addr),
    .wr_addr  (tbl_wr_addr),
    .wr_data  (tbl_wr_data),
    .rd_data  (tbl_rd_data),
    .rd_valid (tbl_rd_valid)
  );

  hbw_ctrl #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_client_id   (in_client_id),
    .in_name_tag    (in_name_tag),
    .in_period      (in_period),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_client_tag (out_client_tag),
    .out_target_id  (out_target_id),
    .out_slot       (out_slot),
    .out_last       (out_last),
    .max_missed     (max_missed_r),
    .dflt_period    (dflt_period_r),
    .tbl_ctl        (tbl_ctl),
    .tbl_rd_addr    (tbl_rd_addr),
    .tbl_wr_addr    (tbl_wr_addr),
    .tbl_wr_data    (tbl_wr_data),
    .tbl_rd_data    (tbl_rd_data),
    .tbl_rd_valid   (tbl_rd_valid)
  );

endmodule

// ===== dv/multi_client_heartbeat_watchdog_tb.sv =====
// Self-checking testbench for the heartbeat watchdog: client table predictor and scoreboard.
module multi_client_heartbeat_watchdog_tb;
  import hbw_pkg::*;

  localparam int ENTRIES = 16;
  localparam int POOL = 24;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 31;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } beat_t;

  class client_table_tracker;
    bit                live [ENTRIES];
    logic [ID_W-1:0]   ids [ENTRIES];
    logic [TAG_W-1:0]  tags [ENTRIES];
    logic [PER_W-1:0]  periods [ENTRIES];
    logic [TIME_W-1:0] fed_at [ENTRIES];
    logic [TIME_W-1:0] now;
    logic [MISS_W-1:0] max_missed;
    logic [PER_W-1:0]  dflt_period;
    beat_t             pending [$];
    int                errors, checked, restarts, fulls, unknowns;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      now = '0;
      max_missed = 8'd3;
      dflt_period = 16'd10;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MAX_MISSED) max_missed = data[MISS_W-1:0];
      else dflt_period = data[PER_W-1:0];
    endfunction

    function void push(logic [1:0] kind, logic [1:0] status, logic [TAG_W-1:0] tag,
                       logic [ID_W-1:0] id, int slot, logic last);
      beat_t b;
      b.kind = kind;
      b.status = status;
      b.tag = tag;
      b.id = id;
      b.slot = SLOT_W'(slot);
      b.last = last;
      pending.push_back(b);
    endfunction

    function void note_command(logic [1:0] act, logic [ID_W-1:0] cid,
                               logic [TAG_W-1:0] ctag, logic [PER_W-1:0] per);
      int hit, free_slot;
      longint unsigned elapsed, allowed;
      hit = -1;
      free_slot = -1;
      case (act)
        ACT_REGISTER: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i]) begin
              if (hit < 0 && (ids[i] == cid || tags[i] == ctag)) hit = i;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (hit < 0 && free_slot >= 0) begin
            hit = free_slot;
            live[hit] = 1'b1;
            tags[hit] = ctag;
          end
          if (hit < 0) begin
            push(KIND_ACK, ST_FULL, '0, cid, 0, 1'b1);
          end else begin
            ids[hit] = cid;
            periods[hit] = (per == '0) ? dflt_period : per;
            fed_at[hit] = now;
            push(KIND_ACK, ST_OK, '0, cid, hit, 1'b1);
          end
        end
        ACT_FEED, ACT_UNREG: begin
          for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && live[i] && ids[i] == cid) hit = i;
          if (hit < 0) begin
            push(KIND_ACK, ST_NOT_FOUND, '0, cid, 0, 1'b1);
          end else begin
            if (act == ACT_FEED) fed_at[hit] = now;
            else live[hit] = 1'b0;
            push(KIND_ACK, ST_OK, '0, cid, hit, 1'b1);
          end
        end
        default: begin
          now = now + 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i]) begin
              elapsed = longint'(TIME_W'(now - fed_at[i]));
              allowed = longint'(max_missed) * longint'(periods[i]);
              if (elapsed > allowed) begin
                fed_at[i] = now;
                push(KIND_RESTART, ST_OK, tags[i], ids[i], i, 1'b0);
              end
            end
          end
          push(KIND_DONE, ST_OK, '0, '0, 0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: kind %0d id %0h slot %0d",
               got.kind, got.id, got.slot);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("status", want.status, got.status);
      compare_field("client_tag", want.tag, got.tag);
      compare_field("target_id", want.id, got.id);
      compare_field("slot", want.slot, got.slot);
      compare_field("last", want.last, got.last);
      if (want.kind == KIND_RESTART) restarts++;
      if (want.kind == KIND_ACK && want.status == ST_FULL) fulls++;
      if (want.kind == KIND_ACK && want.status == ST_NOT_FOUND) unknowns++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = ACT_TICK;
  logic [ID_W-1:0]       in_client_id = '0;
  logic [TAG_W-1:0]      in_name_tag = '0;
  logic [PER_W-1:0]      in_period = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [1:0]            out_kind;
  logic [1:0]            out_status;
  logic [TAG_W-1:0]      out_client_tag;
  logic [ID_W-1:0]       out_target_id;
  logic [SLOT_W-1:0]     out_slot;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  client_table_tracker tracker = new();
  logic [ID_W-1:0]     id_pool [POOL];
  logic [TAG_W-1:0]    tag_pool [POOL];
  int                  gap_odds = 0;
  int                  stall_odds = 0;
  bit                  calm = 1'b0;
  int                  sent = 0;
  int                  cycles = 0;

  multi_client_heartbeat_watchdog #(.ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_client_id(in_client_id), .in_name_tag(in_name_tag), .in_period(in_period),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_status(out_status), .out_client_tag(out_client_tag),
    .out_target_id(out_target_id), .out_slot(out_slot), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("multi_client_heartbeat_watchdog_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_beat({out_kind, out_status, out_client_tag, out_target_id,
                          out_slot, out_last});
  end

  always begin
    @(negedge clk);
    if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    out_ready = 1'b1;
  end

  task automatic send_command(logic [1:0] act, logic [ID_W-1:0] cid,
                              logic [TAG_W-1:0] ctag, logic [PER_W-1:0] per);
    @(negedge clk);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_client_id = cid;
    in_name_tag = ctag;
    in_period = per;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(act, cid, ctag, per);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic issue_random();
    int pick;
    logic [1:0] act;
    logic [ID_W-1:0] cid;
    logic [TAG_W-1:0] ctag;
    logic [PER_W-1:0] per;
    pick = $urandom_range(0, 99);
    act = pick < 30 ? ACT_REGISTER : pick < 55 ? ACT_FEED : pick < 70 ? ACT_UNREG : ACT_TICK;
    cid = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, POOL - 1)];
    ctag = ($urandom_range(0, 9) == 0) ? $urandom : tag_pool[$urandom_range(0, POOL - 1)];
    pick = $urandom_range(0, 9);
    per = pick < 4 ? '0 : pick < 8 ? PER_W'($urandom_range(1, 6)) : PER_W'($urandom);
    send_command(act, cid, ctag, per);
  endtask

  initial begin
    int miss_set [PHASES];
    int period_set [PHASES];
    int pause_at;
    miss_set = '{1, 255, 2, 0, 4};
    period_set = '{1, 65535, 3, 0, 2};
    id_pool[0] = '0;
    id_pool[1] = '1;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < POOL; i++) begin
      id_pool[i] = ID_W'($urandom);
      tag_pool[i] = $urandom;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_command(ACT_REGISTER, '0, '0, '0);
    send_command(ACT_REGISTER, '1, '1, '1);
    send_command(ACT_FEED, ID_W'(5), '0, '0);
    send_command(ACT_UNREG, ID_W'(6), '0, '0);
    send_command(ACT_REGISTER, '1, 32'h0000_1234, 16'd2);
    send_command(ACT_REGISTER, ID_W'(77), '0, 16'd1);
    repeat (4) send_command(ACT_TICK, '1, '1, '1);
    send_command(ACT_FEED, ID_W'(77), '0, '0);
    for (int k = 0; k < 14; k++)
      send_command(ACT_REGISTER, ID_W'(100 + k), 32'hA500_0000 + k, '0);
    send_command(ACT_REGISTER, ID_W'(999), 32'h0000_BEEF, 16'd5);
    send_command(ACT_UNREG, ID_W'(77), '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_reg(CFG_MAX_MISSED, CFG_DATA_W'(miss_set[p]));
      program_reg(CFG_DEFAULT_PERIOD, CFG_DATA_W'(period_set[p]));
      calm = (p == PHASES - 1);
      gap_odds = 3 * $urandom_range(0, 2);
      stall_odds = 3 * $urandom_range(0, 2);
      pause_at = $urandom_range(5, PHASE_ITEMS - 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) settle();
        issue_random();
      end
    end

    settle();
    $display("sent %0d commands, checked %0d result beats: %0d restarts, %0d table-full, %0d unknown-id",
             sent, tracker.checked, tracker.restarts, tracker.fulls, tracker.unknowns);
    $display("config settings swept: reset values, %0d phases incl. zero and maximum registers",
             PHASES);
    if (tracker.errors == 0)
      $display("multi_client_heartbeat_watchdog_tb: PASS");
    else
      $display("multi_client_heartbeat_watchdog_tb: FAIL");
    $finish;
  end
endmodule
